[hw/rtl/huffman_tree_symbol_decoder_macros.svh]
// assertion macros for the huffman tree symbol decoder
`ifndef HUFFMAN_TREE_SYMBOL_DECODER_MACROS_SVH
`define HUFFMAN_TREE_SYMBOL_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define HTSD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("htsd assertion failed");
`define HTSD_ASSERT_NEXT(label, cnd, nxt) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cnd) |=> (nxt)) \
        else $error("htsd assertion failed");
`else
`define HTSD_ASSERT(label, prop)
`define HTSD_ASSERT_NEXT(label, cnd, nxt)
`endif

`endif

[hw/rtl/htsd_pkg.sv]
// shared types and constants for the huffman tree symbol decoder
package htsd_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int NODE_DEPTH  = 515;
    localparam int WINDOW_BITS = 64;

    localparam int IDX_W   = $clog2(NODE_DEPTH);
    localparam int ENTRY_W = 2 * IDX_W;
    localparam int SYM_W   = $clog2(MAX_SYMBOLS);
    localparam int LEN_W   = $clog2(WINDOW_BITS + 1);
    localparam int CNT_W   = $clog2(WINDOW_BITS);
    localparam int SCNT_W  = 9;

    localparam int IN_TDATA_W  = ((3 * IDX_W + WINDOW_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SYM_W + LEN_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SCNT_W-1:0] SYMBOL_COUNT_RST = SCNT_W'(256);
    localparam logic [IDX_W-1:0]  ROOT_NODE_RST    = '0;
    localparam logic [SCNT_W-1:0] LEAF_LIMIT_MAX   = SCNT_W'(MAX_SYMBOLS);
    localparam logic [IDX_W-1:0]  DEPTH_IDX        = IDX_W'(NODE_DEPTH);
    localparam logic [CNT_W-1:0]  LAST_BIT         = CNT_W'(WINDOW_BITS - 1);

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_SYMBOL_COUNT = 1'b0,
        REG_ROOT_NODE    = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } t_ram_wr;

endpackage

[hw/rtl/htsd_node_ram.sv]
// node store: one write port, one registered read port
module htsd_node_ram (
    input  logic                          i_clk,
    input  htsd_pkg::t_ram_wr             i_wr,
    input  logic                          i_rd_en,
    input  logic [htsd_pkg::IDX_W-1:0]    i_rd_addr,
    output logic [htsd_pkg::ENTRY_W-1:0]  o_rd_data
);

    logic [htsd_pkg::ENTRY_W-1:0] r_mem [htsd_pkg::NODE_DEPTH];
    logic [htsd_pkg::ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/huffman_tree_symbol_decoder.sv]
// Huffman tree symbol decoder: walks a code tree in a 515-entry node store, one code bit per
// cycle, taking the window's most significant bit first. A write transfer (tuser 0) loads one
// node's children and gives no result. A decode transfer (tuser 1) runs from acceptance until
// its result is offered as follows: the root read is issued at the accepting edge, then each
// cycle of the walk consumes one bit and reads the next node, then the done state hands the
// result to the output register once that register is free. The walk reads through the single
// read port of the node store. A decode whose root lies outside the store skips the walk and
// finishes with the error flag. New transfers are taken once the previous result sits in the
// output register, taken or not. The node store holds whatever was last written; decoding
// through an unwritten entry gives undefined symbols. Registers: symbol_count at byte
// address 0, root_node at byte address 4.
`include "huffman_tree_symbol_decoder_macros.svh"

module huffman_tree_symbol_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [htsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [htsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [htsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // node_index, left_child, right_child, code_window
    input  logic [htsd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // cmd
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // symbol, code_length
    output logic [htsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // error
    output logic                               m_axis_tuser
);

    localparam int IDX_W   = htsd_pkg::IDX_W;
    localparam int ENTRY_W = htsd_pkg::ENTRY_W;
    localparam int SYM_W   = htsd_pkg::SYM_W;
    localparam int LEN_W   = htsd_pkg::LEN_W;
    localparam int CNT_W   = htsd_pkg::CNT_W;
    localparam int SCNT_W  = htsd_pkg::SCNT_W;
    localparam int WIN_W   = htsd_pkg::WINDOW_BITS;

    // configuration
    logic [SCNT_W-1:0] r_symbol_count;
    logic [IDX_W-1:0]  r_root_node;
    logic              cfg_wr;

    // walk state
    htsd_pkg::t_state r_state, n_state;
    logic [WIN_W-1:0] r_win, n_win;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SYM_W-1:0] r_sym, n_sym;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_err, n_err;

    // output register
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_err;

    // node store
    htsd_pkg::t_ram_wr ram_wr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               in_acc;
    htsd_pkg::t_cmd     in_cmd;
    logic [IDX_W-1:0]   in_node;
    logic [IDX_W-1:0]   in_left;
    logic [IDX_W-1:0]   in_right;
    logic [WIN_W-1:0]   in_win;
    logic [SCNT_W-1:0]  leaf_limit;
    logic [IDX_W-1:0]   child;
    logic               is_leaf;
    logic [LEN_W-1:0]   used;
    logic               out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= htsd_pkg::SYMBOL_COUNT_RST;
            r_root_node    <= htsd_pkg::ROOT_NODE_RST;
        end else if (cfg_wr) begin
            unique case (htsd_pkg::t_reg'(paddr[2]))
                htsd_pkg::REG_SYMBOL_COUNT: begin
                    r_symbol_count <= pwdata[SCNT_W-1:0];
                end
                htsd_pkg::REG_ROOT_NODE: begin
                    r_root_node <= pwdata[IDX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (htsd_pkg::t_reg'(paddr[2]))
            htsd_pkg::REG_SYMBOL_COUNT: prdata = htsd_pkg::APB_DATA_W'(r_symbol_count);
            htsd_pkg::REG_ROOT_NODE:    prdata = htsd_pkg::APB_DATA_W'(r_root_node);
            default:                    prdata = '0;
        endcase
    end

    assign s_axis_tready = (r_state == htsd_pkg::S_IDLE) & i_rst_n;
    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign in_cmd   = htsd_pkg::t_cmd'(s_axis_tuser);
    assign in_node  = s_axis_tdata[IDX_W-1:0];
    assign in_left  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_right = s_axis_tdata[3*IDX_W-1:2*IDX_W];
    assign in_win   = s_axis_tdata[3*IDX_W+WIN_W-1:3*IDX_W];

    assign leaf_limit = (r_symbol_count > htsd_pkg::LEAF_LIMIT_MAX) ?
                        htsd_pkg::LEAF_LIMIT_MAX : r_symbol_count;
    assign child    = r_win[WIN_W-1] ? rd_data[ENTRY_W-1:IDX_W] : rd_data[IDX_W-1:0];
    assign is_leaf  = (child < IDX_W'(leaf_limit));
    assign used     = LEN_W'(r_cnt) + LEN_W'(1);
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_cnt <= n_cnt;
        r_sym <= n_sym;
        r_len <= n_len;
        r_err <= n_err;
    end

    always_comb begin
        n_state = r_state;
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_sym   = r_sym;
        n_len   = r_len;
        n_err   = r_err;
        rd_en   = 1'b0;
        rd_addr = r_root_node;
        ram_wr  = '0;
        unique case (r_state)
            htsd_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == htsd_pkg::CMD_WRITE) begin
                        ram_wr.en   = (in_node < htsd_pkg::DEPTH_IDX);
                        ram_wr.addr = in_node;
                        ram_wr.data = {in_right, in_left};
                    end else if (r_root_node >= htsd_pkg::DEPTH_IDX) begin
                        n_sym   = '0;
                        n_len   = '0;
                        n_err   = 1'b1;
                        n_state = htsd_pkg::S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_root_node;
                        n_win   = in_win;
                        n_cnt   = '0;
                        n_state = htsd_pkg::S_WALK;
                    end
                end
            end
            htsd_pkg::S_WALK: begin
                if (is_leaf) begin
                    n_sym   = child[SYM_W-1:0];
                    n_len   = used;
                    n_err   = 1'b0;
                    n_state = htsd_pkg::S_DONE;
                end else if ((r_cnt == htsd_pkg::LAST_BIT) ||
                             (child >= htsd_pkg::DEPTH_IDX)) begin
                    n_sym   = '0;
                    n_len   = '0;
                    n_err   = 1'b1;
                    n_state = htsd_pkg::S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = child;
                    n_win   = {r_win[WIN_W-2:0], 1'b0};
                    n_cnt   = r_cnt + CNT_W'(1);
                end
            end
            htsd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = htsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = htsd_pkg::S_IDLE;
            end
        endcase
    end

    htsd_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == htsd_pkg::S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == htsd_pkg::S_DONE) && out_free) begin
            r_out_sym <= r_sym;
            r_out_len <= r_len;
            r_out_err <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = htsd_pkg::OUT_TDATA_W'({r_out_len, r_out_sym});
    assign m_axis_tuser  = r_out_err;

    `HTSD_ASSERT(a_err_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    `HTSD_ASSERT(a_len_nonzero, (m_axis_tvalid && !m_axis_tuser) |-> (r_out_len != '0))
    `HTSD_ASSERT_NEXT(a_decode_leaves_idle,
        in_acc && (in_cmd == htsd_pkg::CMD_DECODE), r_state != htsd_pkg::S_IDLE)
    `HTSD_ASSERT_NEXT(a_done_holds,
        (r_state == htsd_pkg::S_DONE) && r_out_valid && !m_axis_tready,
        (r_state == htsd_pkg::S_DONE) && $stable(m_axis_tdata))

endmodule

[test/huffman_tree_symbol_decoder_checker.sv]
// checker for the huffman tree symbol decoder: tracks the node store and compares results
module huffman_tree_symbol_decoder_checker import htsd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic [APB_DATA_W-1:0]   prdata,
    input  logic                    pready,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    // node_index, left_child, right_child, code_window
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic                    s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // symbol, code_length
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // error
    input  logic                    m_axis_tuser,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] code_length;
        logic             error;
    } t_symbol_result;

    logic [ENTRY_W-1:0] node_mem [NODE_DEPTH];
    logic [SCNT_W-1:0]  symbol_count;
    logic [IDX_W-1:0]   root_node;
    t_symbol_result     pending_symbols [$];
    int                 mismatches;

    initial begin
        for (int i = 0; i < NODE_DEPTH; i++) begin
            node_mem[i] = '0;
        end
        mismatches   = 0;
    end

    function automatic t_symbol_result walk_code_tree(input logic [WINDOW_BITS-1:0] window);
        t_symbol_result     res;
        int unsigned        limit;
        int unsigned        node;
        logic [ENTRY_W-1:0] entry;
        res = '0;
        res.error = 1'b1;
        limit = (symbol_count > MAX_SYMBOLS) ? MAX_SYMBOLS : symbol_count;
        node = root_node;
        for (int used = 0; used < WINDOW_BITS; used++) begin
            if (node >= NODE_DEPTH) break;
            entry = node_mem[node];
            node = window[WINDOW_BITS-1-used] ? entry[ENTRY_W-1:IDX_W] : entry[IDX_W-1:0];
            if (node < limit) begin
                res.symbol      = SYM_W'(node);
                res.code_length = LEN_W'(used + 1);
                res.error       = 1'b0;
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_symbol_result          want;
        t_symbol_result          got;
        logic [IDX_W-1:0]        idx;
        logic [APB_DATA_W-1:0]   reg_value;
        if (!i_rst_n) begin
            symbol_count = SYMBOL_COUNT_RST;
            root_node    = ROOT_NODE_RST;
            pending_symbols.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (t_reg'(paddr[APB_ADDR_W-1:2]) == REG_SYMBOL_COUNT) begin
                        symbol_count = pwdata[SCNT_W-1:0];
                    end else begin
                        root_node = pwdata[IDX_W-1:0];
                    end
                end else begin
                    if (t_reg'(paddr[APB_ADDR_W-1:2]) == REG_SYMBOL_COUNT) begin
                        reg_value = APB_DATA_W'(symbol_count);
                    end else begin
                        reg_value = APB_DATA_W'(root_node);
                    end
                    if (prdata !== reg_value) begin
                        $error("prdata: expected %0h, got %0h", reg_value, prdata);
                        mismatches++;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.symbol      = m_axis_tdata[SYM_W-1:0];
                got.code_length = m_axis_tdata[SYM_W+LEN_W-1:SYM_W];
                got.error       = m_axis_tuser;
                if (pending_symbols.size() == 0) begin
                    $error("result transfer with no decode outstanding: symbol %0d", got.symbol);
                    mismatches++;
                end else begin
                    want = pending_symbols.pop_front();
                    if (got.symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
                        mismatches++;
                    end
                    if (got.code_length !== want.code_length) begin
                        $error("code_length: expected %0d, got %0d",
                               want.code_length, got.code_length);
                        mismatches++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, got.error);
                        mismatches++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (t_cmd'(s_axis_tuser) == CMD_WRITE) begin
                    idx = s_axis_tdata[IDX_W-1:0];
                    if (idx < NODE_DEPTH) begin
                        node_mem[idx] = {s_axis_tdata[3*IDX_W-1:2*IDX_W],
                                         s_axis_tdata[2*IDX_W-1:IDX_W]};
                    end
                end else begin
                    pending_symbols.push_back(
                        walk_code_tree(s_axis_tdata[3*IDX_W+WINDOW_BITS-1:3*IDX_W]));
                end
            end
        end
        o_pending    <= pending_symbols.size();
        o_fail_count <= mismatches;
    end

endmodule

[test/huffman_tree_symbol_decoder_tb.sv]
// testbench top for the huffman tree symbol decoder: builds code trees and drives decodes
module huffman_tree_symbol_decoder_tb import htsd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = WINDOW_BITS + 16;
    localparam int IDX_MAX      = (1 << IDX_W) - 1;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr         = '0;
    logic [APB_DATA_W-1:0]   pwdata        = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;

    int fail_count;
    int pending;

    // copy of the store contents, used only to steer code windows down the tree
    int left_of  [NODE_DEPTH];
    int right_of [NODE_DEPTH];
    int leaf_limit   = MAX_SYMBOLS;
    int root_index   = 0;
    int sent_items   = 0;
    int sender_gap   = 33;
    int receiver_gap = 45;

    huffman_tree_symbol_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    huffman_tree_symbol_decoder_checker decode_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_gap);
    end

    initial begin
        #10ms;
        $display("** huffman_tree_symbol_decoder: FAILED **");
        $finish;
    end

    task automatic apb_access(input t_reg r, input logic wr, input logic [APB_DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({r, 2'b00});
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int count, input int root);
        apb_access(REG_SYMBOL_COUNT, 1'b1, APB_DATA_W'(count));
        apb_access(REG_ROOT_NODE, 1'b1, APB_DATA_W'(root));
        apb_access(REG_SYMBOL_COUNT, 1'b0, '0);
        apb_access(REG_ROOT_NODE, 1'b0, '0);
        leaf_limit = (count > MAX_SYMBOLS) ? MAX_SYMBOLS : count;
        root_index = root;
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input t_cmd cmd, input int idx, input int l, input int r,
                             input logic [WINDOW_BITS-1:0] w);
        while ($urandom_range(99) < sender_gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_TDATA_W'({w, IDX_W'(r), IDX_W'(l), IDX_W'(idx)});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == CMD_WRITE && idx < NODE_DEPTH) begin
            left_of[idx]  = l;
            right_of[idx] = r;
        end
    endtask

    task automatic write_node(input int idx, input int l, input int r);
        send_item(CMD_WRITE, idx, l, r, {$urandom, $urandom});
    endtask

    task automatic decode(input logic [WINDOW_BITS-1:0] w);
        send_item(CMD_DECODE, $urandom_range(IDX_MAX), $urandom_range(IDX_MAX),
                  $urandom_range(IDX_MAX), w);
    endtask

    function automatic int pick_child();
        int k;
        k = $urandom_range(19);
        if (k == 0) return $urandom_range(IDX_MAX, NODE_DEPTH);
        if (k < 3) return $urandom_range(15);
        return $urandom_range(NODE_DEPTH - 1);
    endfunction

    // follow is the chance in percent of steering toward an internal child
    function automatic logic [WINDOW_BITS-1:0] guided_window(input int follow);
        logic [WINDOW_BITS-1:0] w;
        int                     node;
        logic                   pick;
        w = {$urandom, $urandom};
        node = root_index;
        for (int b = WINDOW_BITS - 1; b >= 0; b--) begin
            if (node >= NODE_DEPTH) break;
            pick = w[b];
            if ($urandom_range(99) < follow) begin
                if (left_of[node] >= leaf_limit && right_of[node] < leaf_limit) begin
                    pick = 1'b0;
                end else if (right_of[node] >= leaf_limit && left_of[node] < leaf_limit) begin
                    pick = 1'b1;
                end
            end
            w[b] = pick;
            node = pick ? right_of[node] : left_of[node];
            if (node < leaf_limit) break;
        end
        return w;
    endfunction

    task automatic run_phase(input int p);
        int   count, s, root, n, i, k, a, b, j, follow;
        int   pool [$];
        logic skew, grow;
        skew = $urandom_range(1);
        k = $urandom_range(99);
        if (k < 70) count = 2 + $urandom_range(22);
        else if (k < 85) count = 25 + $urandom_range(71);
        else count = 97 + $urandom_range(414);
        case (p)
            0: begin count = 2;   skew = 1'b0; end
            1: begin count = 80;  skew = 1'b1; end
            2: count = 0;
            3: count = 511;
            4: begin count = 30;  skew = 1'b0; end
            5: count = 256;
            6: count = 256;
            7: count = 1;
            8: begin count = 65;  skew = 1'b1; end
            9: count = 12;
            default: ;
        endcase
        s = (count > MAX_SYMBOLS) ? MAX_SYMBOLS : count;
        grow = (s >= 2 && s <= 96);
        if (grow && $urandom_range(9) < 8) root = 2 * s - 2;
        else root = $urandom_range(NODE_DEPTH - 1);
        if ($urandom_range(19) == 0) root = $urandom_range(IDX_MAX, NODE_DEPTH);
        case (p)
            0, 1, 8: root = 2 * s - 2;
            3: root = 256 + $urandom_range(NODE_DEPTH - 257);
            4: root = IDX_MAX;
            5: root = NODE_DEPTH - 1;
            6: root = 0;
            9: root = NODE_DEPTH;
            default: ;
        endcase

        wait_quiet();
        if (sent_items < RANDOM_ITEMS / 3) begin
            sender_gap = 33;
            receiver_gap = 45;
        end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
            sender_gap = 45;
            receiver_gap = 33;
        end else begin
            sender_gap = 0;
            receiver_gap = 0;
        end
        set_config(count, root);

        // random tree shape, or a one-sided chain when skew is set
        if (grow) begin
            pool.delete();
            for (i = 0; i < s; i++) pool.push_back(i);
            for (k = s; k <= 2 * s - 2; k++) begin
                j = $urandom_range(pool.size() - 1);
                a = pool[j];
                pool.delete(j);
                if (skew && k > s) begin
                    b = k - 1;
                end else begin
                    j = $urandom_range(pool.size() - 1);
                    b = pool[j];
                    pool.delete(j);
                end
                if (!skew) pool.push_back(k);
                if ($urandom_range(1)) write_node(k, a, b);
                else write_node(k, b, a);
                sent_items++;
            end
        end

        n = 40 + $urandom_range(60);
        for (i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 4) begin
                write_node($urandom_range(IDX_MAX, NODE_DEPTH), $urandom_range(IDX_MAX),
                           $urandom_range(IDX_MAX));
            end else if (k < 8) begin
                write_node($urandom_range(NODE_DEPTH - 1), pick_child(), pick_child());
            end else if (k < 16) begin
                decode({$urandom, $urandom});
            end else begin
                case ($urandom_range(3))
                    0: follow = 0;
                    1: follow = 50;
                    2: follow = 90;
                    default: follow = 100;
                endcase
                decode(guided_window(follow));
            end
            sent_items++;
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(MAX_SYMBOLS, 0);

        // every store entry gets written before any decode can reach it
        for (p = 0; p < NODE_DEPTH; p++) begin
            write_node(p, pick_child(), pick_child());
            sent_items++;
        end
        wait_quiet();

        set_config(4, 6);
        write_node(4, 0, 1);
        write_node(5, 2, 3);
        write_node(6, 4, 5);
        decode('0);
        decode('1);
        decode({2'b01, 62'h0});
        decode({2'b10, 62'h3fff_ffff_ffff_ffff});
        write_node(IDX_MAX, IDX_MAX, IDX_MAX);
        write_node(NODE_DEPTH, 0, 0);
        decode('1);
        write_node(5, 2, IDX_MAX);
        decode('1);
        decode({2'b10, 62'h0});
        write_node(6, 6, 5);
        decode('0);
        decode({63'h0, 1'b1});

        p = 0;
        while (sent_items < RANDOM_ITEMS) begin
            run_phase(p);
            p++;
        end

        wait_quiet();
        if (fail_count == 0 && pending == 0) begin
            $display("** huffman_tree_symbol_decoder: PASSED **");
        end else begin
            $display("** huffman_tree_symbol_decoder: FAILED **");
        end
        $finish;
    end

endmodule

[huffman_tree_symbol_decoder.f]
+incdir+hw/rtl
hw/rtl/htsd_pkg.sv
hw/rtl/htsd_node_ram.sv
hw/rtl/huffman_tree_symbol_decoder.sv
test/huffman_tree_symbol_decoder_checker.sv
test/huffman_tree_symbol_decoder_tb.sv
